>>> hw/rtl/kiw_pkg.sv
// Shared constants, register indexes and state codes for the inverse-distance weight block.
package kiw_pkg;

    localparam int NUM_EXAMPLES = 16;
    localparam int NUM_DIMS     = 4;
    localparam int COORD_W      = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int DIM_W        = 3;
    localparam int ROW_W        = NUM_DIMS * COORD_W;
    localparam int ACC_W        = 35;
    localparam int ROOT_W       = 36;
    localparam int DIST_W       = 18;
    localparam int RECIP_W      = 33;
    localparam int SUM_W        = 36;
    localparam int NUM_W        = 49;
    localparam int WEIGHT_W     = 17;

    localparam logic [WEIGHT_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [NUM_W-1:0]    RECIP_NUM   = 49'h1_0000_0000;
    localparam logic [ROOT_W-1:0]   ROOT_TOPBIT = 36'h4_0000_0000;
    localparam logic [4:0]          ROOT_STEPS  = 5'd17;
    localparam logic [5:0]          DIV_STEPS   = 6'd48;

    localparam logic [1:0] REG_DIMENSION = 2'd0;
    localparam logic [1:0] REG_COUNT     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_TRD   = 11'b000_0000_0010,
        ST_MUL   = 11'b000_0000_0100,
        ST_ACC   = 11'b000_0000_1000,
        ST_SQRT  = 11'b000_0001_0000,
        ST_SRD   = 11'b000_0010_0000,
        ST_SCMP  = 11'b000_0100_0000,
        ST_RDIV  = 11'b000_1000_0000,
        ST_ORD   = 11'b001_0000_0000,
        ST_OCALC = 11'b010_0000_0000,
        ST_ODIV  = 11'b100_0000_0000
    } state_t;

endpackage

>>> hw/rtl/knn_inverse_distance_weights.sv
// Top level of the k-nearest inverse-distance blend weight engine.
// Usage: pulse start with func and the coordinates while busy is low. A store beat
// (func 0) writes the coordinates into example slot slot_index at the accepting edge
// and produces no result; busy stays low. A query beat (func 1) raises busy and
// produces one weight per example in use, slot 0 first, each shown for one cycle
// with valid high; last marks the final one. The receiver cannot stall results.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data, and
// cfg_ready is always high; write them only while the block is idle.
// Query sequence: each example is read, multiplied and accumulated over each
// dimension, then passed through the bit-serial square root. An exact match stops the
// distance pass early. Otherwise each of the k nearest takes a scan over the
// distance memory plus a reciprocal division. The output pass reads each example
// and runs a further division for each weighted one; both divisions use the single
// shared one-bit-per-cycle divider.
// Reset returns dimension 1, count 1 and threshold 0; the example table and the
// distance memory are not cleared and must be written before use.
module knn_inverse_distance_weights
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [kiw_pkg::IDX_W-1:0]           slot_index,
    input  logic signed [kiw_pkg::COORD_W-1:0]  coord_0,
    input  logic signed [kiw_pkg::COORD_W-1:0]  coord_1,
    input  logic signed [kiw_pkg::COORD_W-1:0]  coord_2,
    input  logic signed [kiw_pkg::COORD_W-1:0]  coord_3,
    output logic                                valid,
    output logic [kiw_pkg::IDX_W-1:0]           weight_index,
    output logic [kiw_pkg::WEIGHT_W-1:0]        weight,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data
);

    kiw_pkg::state_t state_reg, state_next;

    logic [kiw_pkg::DIM_W-1:0]    dim_cfg_reg;
    logic [kiw_pkg::CNT_W-1:0]    cnt_cfg_reg;
    logic [15:0]                  thr_reg;

    logic [kiw_pkg::ROW_W-1:0]    query_reg, query_next;
    logic [kiw_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [1:0]                   csel_reg, csel_next;
    logic [kiw_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [31:0]                  prod_reg, prod_next;
    logic [kiw_pkg::ROOT_W-1:0]   sq_v_reg, sq_v_next;
    logic [kiw_pkg::ROOT_W-1:0]   sq_r_reg, sq_r_next;
    logic [kiw_pkg::ROOT_W-1:0]   sq_bit_reg, sq_bit_next;
    logic [4:0]                   sq_cnt_reg, sq_cnt_next;
    logic                         exact_reg, exact_next;
    logic [kiw_pkg::IDX_W-1:0]    exact_idx_reg, exact_idx_next;
    logic [kiw_pkg::NUM_EXAMPLES-1:0] chosen_reg, chosen_next;
    logic [kiw_pkg::DIM_W-1:0]    pass_reg, pass_next;
    logic                         have_reg, have_next;
    logic [kiw_pkg::IDX_W-1:0]    best_reg, best_next;
    logic [kiw_pkg::DIST_W-1:0]   best_d_reg, best_d_next;
    logic [kiw_pkg::IDX_W-1:0]    nearest_reg, nearest_next;
    logic [kiw_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [kiw_pkg::NUM_W-1:0]    div_num_reg, div_num_next;
    logic [kiw_pkg::SUM_W-1:0]    div_den_reg, div_den_next;
    logic [kiw_pkg::SUM_W-1:0]    div_rem_reg, div_rem_next;
    logic [kiw_pkg::NUM_W-1:0]    div_q_reg, div_q_next;
    logic [5:0]                   div_cnt_reg, div_cnt_next;
    logic                         valid_reg, valid_next;
    logic [kiw_pkg::IDX_W-1:0]    windex_reg, windex_next;
    logic [kiw_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic                         last_reg, last_next;

    // Example table and distance memory, each with a registered synchronous read.
    logic [kiw_pkg::ROW_W-1:0]    tbl_mem [kiw_pkg::NUM_EXAMPLES];
    logic [kiw_pkg::ROW_W-1:0]    tbl_rd_reg;
    logic [kiw_pkg::RECIP_W-1:0]  dist_mem [kiw_pkg::NUM_EXAMPLES];
    logic [kiw_pkg::RECIP_W-1:0]  dist_rd_reg;
    logic                         dist_we;
    logic [kiw_pkg::IDX_W-1:0]    dist_wa;
    logic [kiw_pkg::RECIP_W-1:0]  dist_wd;
    logic                         store_beat;

    logic [kiw_pkg::DIM_W-1:0]    dim_eff;
    logic [kiw_pkg::CNT_W-1:0]    cnt_eff;
    logic [kiw_pkg::CNT_W-1:0]    k_eff;
    logic [kiw_pkg::CNT_W-1:0]    idx_inc;
    logic                         idx_at_end;
    logic signed [kiw_pkg::COORD_W:0] diff;
    logic [kiw_pkg::COORD_W:0]    diff_abs;
    logic [kiw_pkg::ROOT_W-1:0]   sq_trial;
    logic                         sq_take;
    logic [kiw_pkg::ROOT_W-1:0]   sq_r_step;
    logic [kiw_pkg::DIST_W-1:0]   cur_d;
    logic                         sel_take;
    logic [kiw_pkg::IDX_W-1:0]    best_fin;
    logic [kiw_pkg::DIST_W-1:0]   best_d_fin;
    logic [kiw_pkg::DIST_W-1:0]   recip_den;
    logic [kiw_pkg::SUM_W:0]      div_sh;
    logic                         div_ge;
    logic [kiw_pkg::SUM_W-1:0]    div_rem_step;
    logic [kiw_pkg::NUM_W-1:0]    div_q_step;
    logic                         emit;
    logic [kiw_pkg::WEIGHT_W-1:0] emit_weight;

    assign store_beat = start && (state_reg == kiw_pkg::ST_IDLE)
                        && (func == kiw_pkg::FUNC_STORE);
    assign busy       = (state_reg != kiw_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign valid        = valid_reg;
    assign weight_index = windex_reg;
    assign weight       = weight_reg;
    assign last         = last_reg;

    always_comb
    begin
        if (dim_cfg_reg == 3'd0)
            dim_eff = 3'd1;
        else if (dim_cfg_reg > 3'(kiw_pkg::NUM_DIMS))
            dim_eff = 3'(kiw_pkg::NUM_DIMS);
        else
            dim_eff = dim_cfg_reg;
        if (cnt_cfg_reg == 5'd0)
            cnt_eff = 5'd1;
        else if (cnt_cfg_reg > 5'(kiw_pkg::NUM_EXAMPLES))
            cnt_eff = 5'(kiw_pkg::NUM_EXAMPLES);
        else
            cnt_eff = cnt_cfg_reg;
        if ({2'b00, dim_eff} + 5'd1 > cnt_eff)
            k_eff = cnt_eff;
        else
            k_eff = {2'b00, dim_eff} + 5'd1;
    end

    assign idx_inc    = idx_reg + 5'd1;
    assign idx_at_end = (idx_inc == cnt_eff);

    // Absolute difference of one coordinate; it is squared in the multiply state.
    always_comb
    begin
        diff = {query_reg[csel_reg*kiw_pkg::COORD_W + kiw_pkg::COORD_W-1],
                query_reg[csel_reg*kiw_pkg::COORD_W +: kiw_pkg::COORD_W]}
             - {tbl_rd_reg[csel_reg*kiw_pkg::COORD_W + kiw_pkg::COORD_W-1],
                tbl_rd_reg[csel_reg*kiw_pkg::COORD_W +: kiw_pkg::COORD_W]};
        diff_abs = diff[kiw_pkg::COORD_W] ? 17'(-diff) : 17'(diff);
    end

    // One step of the digit-by-digit integer square root.
    always_comb
    begin
        sq_trial  = sq_r_reg + sq_bit_reg;
        sq_take   = (sq_v_reg >= sq_trial);
        sq_r_step = sq_take ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
    end

    // One step of the shared restoring divider.
    always_comb
    begin
        div_sh       = {div_rem_reg, div_num_reg[kiw_pkg::NUM_W-1]};
        div_ge       = (div_sh >= {1'b0, div_den_reg});
        div_rem_step = div_ge ? 36'(div_sh - {1'b0, div_den_reg}) : 36'(div_sh);
        div_q_step   = {div_q_reg[kiw_pkg::NUM_W-2:0], div_ge};
    end

    // Running minimum over unchosen distances; strict compare keeps the lower slot.
    always_comb
    begin
        cur_d      = dist_rd_reg[kiw_pkg::DIST_W-1:0];
        sel_take   = !chosen_reg[idx_reg[3:0]] && (!have_reg || (cur_d < best_d_reg));
        best_fin   = sel_take ? idx_reg[3:0] : best_reg;
        best_d_fin = sel_take ? cur_d : best_d_reg;
        if (best_d_fin > {2'b00, thr_reg})
            recip_den = best_d_fin;
        else
            recip_den = {2'b00, thr_reg};
        if (recip_den == '0)
            recip_den = 18'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        query_next     = query_reg;
        idx_next       = idx_reg;
        csel_next      = csel_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sq_v_next      = sq_v_reg;
        sq_r_next      = sq_r_reg;
        sq_bit_next    = sq_bit_reg;
        sq_cnt_next    = sq_cnt_reg;
        exact_next     = exact_reg;
        exact_idx_next = exact_idx_reg;
        chosen_next    = chosen_reg;
        pass_next      = pass_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        best_d_next    = best_d_reg;
        nearest_next   = nearest_reg;
        sum_next       = sum_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        windex_next    = windex_reg;
        weight_next    = weight_reg;
        last_next      = 1'b0;
        valid_next     = 1'b0;
        dist_we        = 1'b0;
        dist_wa        = idx_reg[3:0];
        dist_wd        = '0;
        emit           = 1'b0;
        emit_weight    = '0;

        unique case (state_reg)
            kiw_pkg::ST_IDLE:
            begin
                if (start && (func == kiw_pkg::FUNC_QUERY))
                begin
                    query_next = {coord_3, coord_2, coord_1, coord_0};
                    idx_next   = '0;
                    exact_next = 1'b0;
                    sum_next   = '0;
                    state_next = kiw_pkg::ST_TRD;
                end
            end
            kiw_pkg::ST_TRD:
            begin
                csel_next  = '0;
                acc_next   = '0;
                state_next = kiw_pkg::ST_MUL;
            end
            kiw_pkg::ST_MUL:
            begin
                prod_next  = {15'd0, diff_abs} * {15'd0, diff_abs};
                state_next = kiw_pkg::ST_ACC;
            end
            kiw_pkg::ST_ACC:
            begin
                acc_next = acc_reg + {3'b000, prod_reg};
                if ({1'b0, csel_reg} == dim_eff - 3'd1)
                begin
                    sq_v_next   = {1'b0, acc_next};
                    sq_r_next   = '0;
                    sq_bit_next = kiw_pkg::ROOT_TOPBIT;
                    sq_cnt_next = '0;
                    state_next  = kiw_pkg::ST_SQRT;
                end
                else
                begin
                    csel_next  = csel_reg + 2'd1;
                    state_next = kiw_pkg::ST_MUL;
                end
            end
            kiw_pkg::ST_SQRT:
            begin
                sq_v_next   = sq_take ? (sq_v_reg - sq_trial) : sq_v_reg;
                sq_r_next   = sq_r_step;
                sq_bit_next = sq_bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == kiw_pkg::ROOT_STEPS)
                begin
                    dist_we = 1'b1;
                    dist_wd = {15'd0, sq_r_step[kiw_pkg::DIST_W-1:0]};
                    if (sq_r_step[kiw_pkg::DIST_W-1:0] <= {2'b00, thr_reg})
                    begin
                        // The first exact match in slot order wins outright.
                        exact_next     = 1'b1;
                        exact_idx_next = idx_reg[3:0];
                        idx_next       = '0;
                        state_next     = kiw_pkg::ST_ORD;
                    end
                    else if (idx_at_end)
                    begin
                        idx_next    = '0;
                        pass_next   = '0;
                        chosen_next = '0;
                        have_next   = 1'b0;
                        state_next  = kiw_pkg::ST_SRD;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = kiw_pkg::ST_TRD;
                    end
                end
            end
            kiw_pkg::ST_SRD:
            begin
                state_next = kiw_pkg::ST_SCMP;
            end
            kiw_pkg::ST_SCMP:
            begin
                best_next   = best_fin;
                best_d_next = best_d_fin;
                have_next   = have_reg || sel_take;
                if (idx_at_end)
                begin
                    chosen_next[best_fin] = 1'b1;
                    if (pass_reg == 3'd0)
                        nearest_next = best_fin;
                    div_num_next = kiw_pkg::RECIP_NUM;
                    div_den_next = {18'd0, recip_den};
                    div_rem_next = '0;
                    div_q_next   = '0;
                    div_cnt_next = '0;
                    state_next   = kiw_pkg::ST_RDIV;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = kiw_pkg::ST_SRD;
                end
            end
            kiw_pkg::ST_RDIV:
            begin
                div_num_next = div_num_reg << 1;
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == kiw_pkg::DIV_STEPS)
                begin
                    // The chosen slot now holds its reciprocal instead of its distance.
                    dist_we   = 1'b1;
                    dist_wa   = best_reg;
                    dist_wd   = div_q_step[kiw_pkg::RECIP_W-1:0];
                    sum_next  = sum_reg + {3'b000, div_q_step[kiw_pkg::RECIP_W-1:0]};
                    pass_next = pass_reg + 3'd1;
                    idx_next  = '0;
                    have_next = 1'b0;
                    if ({2'b00, pass_reg} + 5'd1 == k_eff)
                        state_next = kiw_pkg::ST_ORD;
                    else
                        state_next = kiw_pkg::ST_SRD;
                end
            end
            kiw_pkg::ST_ORD:
            begin
                state_next = kiw_pkg::ST_OCALC;
            end
            kiw_pkg::ST_OCALC:
            begin
                if (exact_reg)
                begin
                    emit        = 1'b1;
                    emit_weight = (idx_reg[3:0] == exact_idx_reg) ? kiw_pkg::ONE_Q16 : '0;
                end
                else if ((k_eff == 5'd1) || (sum_reg == '0))
                begin
                    emit        = 1'b1;
                    emit_weight = (idx_reg[3:0] == nearest_reg) ? kiw_pkg::ONE_Q16 : '0;
                end
                else if (chosen_reg[idx_reg[3:0]])
                begin
                    div_num_next = {dist_rd_reg, 16'd0};
                    div_den_next = sum_reg;
                    div_rem_next = '0;
                    div_q_next   = '0;
                    div_cnt_next = '0;
                    state_next   = kiw_pkg::ST_ODIV;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            kiw_pkg::ST_ODIV:
            begin
                div_num_next = div_num_reg << 1;
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == kiw_pkg::DIV_STEPS)
                begin
                    emit        = 1'b1;
                    emit_weight = div_q_step[kiw_pkg::WEIGHT_W-1:0];
                end
            end
            default:
            begin
                state_next = kiw_pkg::ST_IDLE;
            end
        endcase

        if (emit)
        begin
            valid_next  = 1'b1;
            windex_next = idx_reg[3:0];
            weight_next = emit_weight;
            last_next   = idx_at_end;
            if (idx_at_end)
                state_next = kiw_pkg::ST_IDLE;
            else
            begin
                idx_next   = idx_inc;
                state_next = kiw_pkg::ST_ORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kiw_pkg::ST_IDLE;
            dim_cfg_reg <= 3'd1;
            cnt_cfg_reg <= 5'd1;
            thr_reg     <= '0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
            exact_reg   <= 1'b0;
            have_reg    <= 1'b0;
            chosen_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            exact_reg  <= exact_next;
            have_reg   <= have_next;
            chosen_reg <= chosen_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == kiw_pkg::REG_DIMENSION)
                    dim_cfg_reg <= cfg_data[2:0];
                else if (cfg_index == kiw_pkg::REG_COUNT)
                    cnt_cfg_reg <= cfg_data[4:0];
                else if (cfg_index == kiw_pkg::REG_THRESHOLD)
                    thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        idx_reg        <= idx_next;
        csel_reg       <= csel_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        sq_v_reg       <= sq_v_next;
        sq_r_reg       <= sq_r_next;
        sq_bit_reg     <= sq_bit_next;
        sq_cnt_reg     <= sq_cnt_next;
        exact_idx_reg  <= exact_idx_next;
        pass_reg       <= pass_next;
        best_reg       <= best_next;
        best_d_reg     <= best_d_next;
        nearest_reg    <= nearest_next;
        sum_reg        <= sum_next;
        div_num_reg    <= div_num_next;
        div_den_reg    <= div_den_next;
        div_rem_reg    <= div_rem_next;
        div_q_reg      <= div_q_next;
        div_cnt_reg    <= div_cnt_next;
        windex_reg     <= windex_next;
        weight_reg     <= weight_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_beat)
            tbl_mem[slot_index] <= {coord_3, coord_2, coord_1, coord_0};
        tbl_rd_reg <= tbl_mem[idx_reg[3:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        dist_rd_reg <= dist_mem[idx_reg[3:0]];
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register lost its one-hot code");

    a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(busy))
        else $error("result beat without a query in progress");

    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> valid_reg)
        else $error("last flag raised outside a result beat");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (weight_reg <= kiw_pkg::ONE_Q16))
        else $error("weight above 1.0");
`endif

endmodule
